// ===== design/delimited_field_extractor_macros.svh =====
// ----------------------------------------------------------------------------
// Delimited field extractor assertion macros
// Shared property wrappers on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_FIELD_EXTRACTOR_MACROS_SVH
`define DELIMITED_FIELD_EXTRACTOR_MACROS_SVH

// same-cycle implication
`define DFE_ASSERT_IMPLY(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) else $error(msg);

// next-cycle implication
`define DFE_ASSERT_NEXT(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) else $error(msg);

`endif

// ===== design/dfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_pkg
// Types, codes and helpers shared by the delimited field extractor.
// ----------------------------------------------------------------------------
package dfe_pkg;

   localparam int MAX_DELIM_LEN = 8;
   localparam int LEN_W         = 4;
   localparam int IDX_W         = $clog2(MAX_DELIM_LEN);

   localparam logic [7:0] NEWLINE = 8'd10;

   // result kinds
   localparam logic [1:0] KIND_CONTENT  = 2'd0;
   localparam logic [1:0] KIND_CLOSED   = 2'd1;
   localparam logic [1:0] KIND_EOL_OPEN = 2'd2;
   localparam logic [1:0] KIND_EOL_IDLE = 2'd3;

   // register indexes
   localparam logic [2:0] REG_START_WORD = 3'd0;
   localparam logic [2:0] REG_START_LEN  = 3'd1;
   localparam logic [2:0] REG_END_WORD   = 3'd2;
   localparam logic [2:0] REG_END_LEN    = 3'd3;
   localparam logic [2:0] REG_START_OPT  = 3'd4;
   localparam logic [2:0] REG_END_OPT    = 3'd5;

   typedef struct packed {
      logic             accept;
      logic             emit_prefix;
      logic             emit_final;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic             out_free;
      logic             has_result;
      logic [IDX_W-1:0] flush_n;
   } sts_type;

   // clamp a delimiter length into 1..MAX_DELIM_LEN
   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] r;
      if (len == '0) begin
         r = LEN_W'(1);
      end else if (len > LEN_W'(MAX_DELIM_LEN)) begin
         r = LEN_W'(MAX_DELIM_LEN);
      end else begin
         r = len;
      end
      return r;
   endfunction

endpackage

// ===== design/delimited_field_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_field_extractor
// Passes on the text between a start and an end delimiter, line by line.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  byte stream in, one byte per transfer (valid/stall).
//   rsp_*  results out (kind, data, last), one per transfer (valid/stall).
//   csr_*  register writes; csr_ready is always high, write only while idle.
// Output: a byte's first result is on rsp_* in the cycle after it is taken.
// Throughput: one byte per cycle unless rsp_stall or a flush holds it. A byte
//   that breaks a partial end match of k bytes (or a newline during one) yields
//   k+1 results, one per cycle unless stalled, and req_stall is high until the
//   last of them is loaded. Bytes that only advance a match give no result.
// Reset: registers take their defaults (lengths 1, words zero, both
//   delimiters required), no field is open and no match is in progress.
// Receiver stall: the output register holds its result; a new byte is taken
//   only in a cycle where the output register is empty or being drained.
// ----------------------------------------------------------------------------
`include "delimited_field_extractor_macros.svh"

module delimited_field_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   dfe_pkg::cmd_type cmd;
   dfe_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   dfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dfe_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_in_byte (req_in_byte),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_kind    (rsp_kind),
      .rsp_data    (rsp_data),
      .rsp_last    (rsp_last),
      .cmd         (cmd),
      .sts         (sts)
   );

   `DFE_ASSERT_NEXT(a_flush_blocks_input, cmd.accept && (sts.flush_n != '0), req_stall, "input taken during prefix flush")
   `DFE_ASSERT_IMPLY(a_prefix_is_content, rsp_valid && !rsp_last, rsp_kind == dfe_pkg::KIND_CONTENT, "non-final result is not content")
   `DFE_ASSERT_IMPLY(a_report_data_zero, rsp_valid && (rsp_kind != dfe_pkg::KIND_CONTENT), rsp_data == 8'd0, "report carries data")
   `DFE_ASSERT_IMPLY(a_accept_needs_room, cmd.accept, sts.out_free, "byte taken with output register full")

endmodule

// ===== design/dfe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_ctrl
// Sequencer: takes bytes, steps prefix flush one result per unstalled cycle.
// ----------------------------------------------------------------------------
module dfe_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dfe_pkg::sts_type  sts,
   output dfe_pkg::cmd_type  cmd
);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_FLUSH
   } state_type;

   state_type                     state_ff, state_in;
   logic [dfe_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic [dfe_pkg::IDX_W-1:0]     flush_n_ff, flush_n_in;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      flush_n_in = flush_n_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = !sts.out_free;
            cmd.accept = req_valid && sts.out_free;
            if (cmd.accept) begin
               if (sts.flush_n != '0) begin
                  cmd.emit_prefix = 1'b1;
                  idx_in          = dfe_pkg::IDX_W'(1);
                  flush_n_in      = sts.flush_n;
                  state_in        = ST_FLUSH;
               end else begin
                  cmd.emit_final = sts.has_result;
               end
            end
         end
         ST_FLUSH: begin
            if (sts.out_free) begin
               if (idx_ff < flush_n_ff) begin
                  cmd.emit_prefix = 1'b1;
                  cmd.idx         = idx_ff;
                  idx_in          = idx_ff + dfe_pkg::IDX_W'(1);
               end else begin
                  cmd.emit_final = 1'b1;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         idx_ff     <= '0;
         flush_n_ff <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         flush_n_ff <= flush_n_in;
      end
   end

endmodule

// ===== design/dfe_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_datapath
// Config registers, match state, pending final result and output register.
// ----------------------------------------------------------------------------
module dfe_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [2:0]             csr_index,
   input  logic [63:0]            csr_wdata,
   input  logic [7:0]             req_in_byte,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_kind,
   output logic [7:0]             rsp_data,
   output logic                   rsp_last,
   input  dfe_pkg::cmd_type       cmd,
   output dfe_pkg::sts_type       sts
);

   localparam int LW = dfe_pkg::LEN_W;
   localparam int IW = dfe_pkg::IDX_W;

   logic [63:0]     start_word_ff, end_word_ff;
   logic [LW-1:0]   start_len_ff, end_len_ff;
   logic            start_opt_ff, end_opt_ff;

   logic            inside_ff, inside_in;
   logic [IW-1:0]   match_ff, match_in;
   logic [1:0]      fin_kind_ff, fin_kind_in;
   logic [7:0]      fin_data_ff, fin_data_in;

   logic            out_valid_ff;
   logic [1:0]      out_kind_ff;
   logic [7:0]      out_data_ff;
   logic            out_last_ff;

   logic [LW-1:0]   slen, elen, mc_next;
   logic [IW-1:0]   mc_s, mc_e;
   logic [7:0]      s_byte, e_byte;
   logic            has_result;
   logic [IW-1:0]   flush_n;
   logic [1:0]      fin_kind_sel;
   logic [7:0]      fin_data_sel;

   always_comb begin
      slen = dfe_pkg::eff_len(start_len_ff);
      elen = dfe_pkg::eff_len(end_len_ff);
      mc_s = ({1'b0, match_ff} >= slen) ? '0 : match_ff;
      mc_e = ({1'b0, match_ff} >= elen) ? '0 : match_ff;
      s_byte = start_word_ff[{mc_s, 3'b000} +: 8];
      e_byte = end_word_ff[{mc_e, 3'b000} +: 8];

      inside_in   = inside_ff;
      match_in    = match_ff;
      has_result  = 1'b0;
      flush_n     = '0;
      fin_kind_in = dfe_pkg::KIND_CONTENT;
      fin_data_in = 8'd0;
      mc_next     = '0;

      if (req_in_byte == dfe_pkg::NEWLINE) begin
         has_result = 1'b1;
         if (inside_ff) begin
            if (end_opt_ff) begin
               fin_kind_in = dfe_pkg::KIND_CLOSED;
            end else begin
               flush_n     = mc_e;
               fin_kind_in = dfe_pkg::KIND_EOL_OPEN;
            end
         end else begin
            fin_kind_in = dfe_pkg::KIND_EOL_IDLE;
         end
         inside_in = start_opt_ff;
         match_in  = '0;
      end else if (!inside_ff) begin
         if (s_byte == req_in_byte) begin
            mc_next = {1'b0, mc_s} + LW'(1);
            if (mc_next >= slen) begin
               inside_in = 1'b1;
               match_in  = '0;
            end else begin
               match_in  = mc_next[IW-1:0];
            end
         end else begin
            match_in = '0;
         end
      end else if (end_opt_ff) begin
         match_in    = '0;
         has_result  = 1'b1;
         fin_data_in = req_in_byte;
      end else begin
         if (e_byte == req_in_byte) begin
            mc_next = {1'b0, mc_e} + LW'(1);
            if (mc_next >= elen) begin
               has_result  = 1'b1;
               fin_kind_in = dfe_pkg::KIND_CLOSED;
               inside_in   = start_opt_ff;
               match_in    = '0;
            end else begin
               match_in    = mc_next[IW-1:0];
            end
         end else begin
            has_result  = 1'b1;
            flush_n     = mc_e;
            fin_data_in = req_in_byte;
            match_in    = '0;
         end
      end

      fin_kind_sel = cmd.accept ? fin_kind_in : fin_kind_ff;
      fin_data_sel = cmd.accept ? fin_data_in : fin_data_ff;

      sts.out_free   = !out_valid_ff || !rsp_stall;
      sts.has_result = has_result;
      sts.flush_n    = flush_n;
   end

   // configuration and match state
   always_ff @(posedge clock) begin
      if (reset) begin
         start_word_ff <= '0;
         start_len_ff  <= LW'(1);
         end_word_ff   <= '0;
         end_len_ff    <= LW'(1);
         start_opt_ff  <= 1'b0;
         end_opt_ff    <= 1'b0;
         inside_ff     <= 1'b0;
         match_ff      <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               dfe_pkg::REG_START_WORD: start_word_ff <= csr_wdata;
               dfe_pkg::REG_START_LEN:  start_len_ff  <= csr_wdata[LW-1:0];
               dfe_pkg::REG_END_WORD:   end_word_ff   <= csr_wdata;
               dfe_pkg::REG_END_LEN:    end_len_ff    <= csr_wdata[LW-1:0];
               dfe_pkg::REG_START_OPT:  start_opt_ff  <= csr_wdata[0];
               dfe_pkg::REG_END_OPT:    end_opt_ff    <= csr_wdata[0];
               default: ;
            endcase
         end
         if (cmd.accept) begin
            inside_ff <= inside_in;
            match_ff  <= match_in;
         end
      end
   end

   // pending final result and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_prefix || cmd.emit_final) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         fin_kind_ff <= fin_kind_in;
         fin_data_ff <= fin_data_in;
      end
      if (cmd.emit_prefix) begin
         out_kind_ff <= dfe_pkg::KIND_CONTENT;
         out_data_ff <= end_word_ff[{cmd.idx, 3'b000} +: 8];
         out_last_ff <= 1'b0;
      end else if (cmd.emit_final) begin
         out_kind_ff <= fin_kind_sel;
         out_data_ff <= fin_data_sel;
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_data  = out_data_ff;
   assign rsp_last  = out_last_ff;

endmodule
